// ===== rtl/paw_pkg.sv =====
package paw_pkg;

  localparam int PosW    = 32;
  localparam int VelW    = 16;
  localparam int DelayW  = 16;
  localparam int MarkW   = 8;
  localparam int TimerW  = 7;
  localparam int RangeW  = 15;
  localparam int CfgIdxW = 1;
  localparam int DefaultFracBits = 8;
  localparam int FifoDepth = 4;
  // offset magnitude of two 32-bit values, in whole units, fits 33 bits
  localparam int MagW = PosW + 1;

  localparam logic [RangeW-1:0] HRangeReset  = 15'd550;
  localparam logic [RangeW-1:0] VRangeReset  = 15'd166;
  localparam logic [TimerW-1:0] TimerRunning = 7'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHRange = 1'b0,
    CfgVRange = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
    logic signed [PosW-1:0]   pos_z;
    logic signed [VelW-1:0]   vel_x;
    logic signed [VelW-1:0]   vel_y;
    logic signed [VelW-1:0]   vel_z;
    logic [DelayW-1:0]        delay;
    logic [MarkW-1:0]         mark;
    logic signed [PosW-1:0]   center_x;
    logic signed [PosW-1:0]   center_y;
    logic signed [PosW-1:0]   center_z;
    logic [TimerW-1:0]        effect_timer;
  } in_req_t;

  typedef struct packed {
    logic signed [PosW-1:0]   new_pos_x;
    logic signed [PosW-1:0]   new_pos_y;
    logic signed [PosW-1:0]   new_pos_z;
    logic signed [VelW-1:0]   new_vel_y;
    logic [DelayW-1:0]        new_delay;
    logic [MarkW-1:0]         new_mark;
    logic                     killed;
  } out_req_t;

  // per axis classification from the front part
  typedef struct packed {
    logic                     wrap;   // outside window
    logic                     neg;    // below
    logic [MagW-1:0]          whole;  // |offset| in whole units
    logic signed [PosW-1:0]   pos;    // moved position
    logic signed [PosW-1:0]   ctr;
  } axis_t;

  typedef struct packed {
    axis_t                    ax;
    axis_t                    ay;
    axis_t                    az;
    logic                     waiting;
    logic                     kill;
    logic signed [VelW-1:0]   vel_y;
    logic [DelayW-1:0]        delay;
    logic [MarkW-1:0]         mark;
    logic [RangeW-1:0]        hr;
    logic [RangeW-1:0]        vr;
  } job_t;

  function automatic logic signed [PosW-1:0] sat32(input logic signed [PosW+1:0] v);
    logic signed [PosW+1:0] mx;
    logic signed [PosW+1:0] mn;
    mx = (PosW+2)'(signed'({1'b0, {(PosW-1){1'b1}}}));
    mn = -mx - (PosW+2)'(1);
    if (v > mx) return mx[PosW-1:0];
    if (v < mn) return mn[PosW-1:0];
    return v[PosW-1:0];
  endfunction

endpackage

// ===== rtl/paw_if.sv =====
interface paw_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/paw_front.sv =====
module paw_front import paw_pkg::*; #(
  parameter int FracBits = DefaultFracBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RangeW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_req_t           in_data_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output job_t              job_o
);

  logic [RangeW-1:0] hr_q, vr_q;
  logic              vld_q;
  job_t              job_q, job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_q <= HRangeReset;
      vr_q <= VRangeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgHRange: hr_q <= cfg_data_i;
        CfgVRange: vr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic axis_t classify(input logic signed [PosW-1:0] p,
                                     input logic signed [VelW-1:0] v,
                                     input logic signed [PosW-1:0] c,
                                     input logic [RangeW-1:0] r);
    axis_t a;
    logic signed [PosW+1:0] diff;
    logic [PosW+1:0] mag;
    a.pos  = sat32((PosW+2)'(p) + (PosW+2)'(v));
    a.ctr  = c;
    diff   = (PosW+2)'(a.pos) - (PosW+2)'(c);
    a.neg  = diff[PosW+1];
    mag    = a.neg ? (PosW+2)'(-diff) : (PosW+2)'(diff);
    a.whole = MagW'(mag >> FracBits);
    a.wrap = a.whole > MagW'(r);
    return a;
  endfunction

  logic [RangeW-1:0] hr, vr;
  logic [DelayW-1:0] dec;
  assign hr  = (hr_q == '0) ? RangeW'(1) : hr_q;
  assign vr  = (vr_q == '0) ? RangeW'(1) : vr_q;
  assign dec = (in_data_i.delay != '0) ? in_data_i.delay - DelayW'(1) : '0;

  always_comb begin
    job_d       = '0;
    job_d.ax    = classify(in_data_i.pos_x, in_data_i.vel_x, in_data_i.center_x, hr);
    job_d.ay    = classify(in_data_i.pos_y, in_data_i.vel_y, in_data_i.center_y, vr);
    job_d.az    = classify(in_data_i.pos_z, in_data_i.vel_z, in_data_i.center_z, hr);
    job_d.waiting = dec != '0;
    if (job_d.waiting) begin
      job_d.ax.pos = in_data_i.pos_x;
      job_d.ay.pos = in_data_i.pos_y;
      job_d.az.pos = in_data_i.pos_z;
      job_d.ax.wrap = 1'b0;
      job_d.ay.wrap = 1'b0;
      job_d.az.wrap = 1'b0;
    end
    job_d.kill  = job_d.ay.wrap && job_d.ay.neg && (in_data_i.effect_timer < TimerRunning);
    if (job_d.kill) job_d.ay.wrap = 1'b0;
    job_d.vel_y = job_d.kill ? '0 : in_data_i.vel_y;
    job_d.mark  = job_d.kill ? '0 : in_data_i.mark;
    job_d.delay = dec;
    job_d.hr    = hr;
    job_d.vr    = vr;
  end

  assign in_ready_o = !vld_q || job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (in_ready_o) vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) job_q <= job_d;
  end

  assign job_valid_o = vld_q;
  assign job_o       = job_q;

endmodule

// ===== rtl/paw_fifo.sv =====
module paw_fifo import paw_pkg::*; #(
  parameter int Depth = FifoDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != (AW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + AW'(1);
      if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= (AW+1)'(Depth);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("fifo overflow");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + (AW+1)'(1)) else $error("fifo count");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wp_q == rp_q) else $error("fifo pointers");

endmodule

// ===== rtl/paw_back.sv =====
module paw_back import paw_pkg::*; #(
  parameter int FracBits = DefaultFracBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  job_t     job_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_data_o
);

  // whole offset mod range, reduced MSB first a few bits per stage; the partial
  // remainder stays below the range, so one compare and subtract per bit
  localparam int BitsPerStage = 3;
  localparam int NumStages    = (MagW + BitsPerStage - 1) / BitsPerStage;
  localparam int PadW         = NumStages * BitsPerStage;
  localparam int RemW         = RangeW + 1;

  function automatic logic [BitsPerStage-1:0] chunk(input logic [MagW-1:0] w,
                                                    input int k);
    logic [PadW-1:0] wp;
    wp = PadW'(w);
    return wp[PadW-1-k*BitsPerStage -: BitsPerStage];
  endfunction

  function automatic logic [RangeW-1:0] rem_step(input logic [RangeW-1:0] rem,
                                                 input logic [BitsPerStage-1:0] bits,
                                                 input logic [RangeW-1:0] r);
    logic [RemW-1:0]   t;
    logic [RangeW-1:0] x;
    x = rem;
    for (int i = BitsPerStage - 1; i >= 0; i--) begin
      t = {x, bits[i]};
      if (t >= RemW'(r)) t = t - RemW'(r);
      x = t[RangeW-1:0];
    end
    return x;
  endfunction

  function automatic logic signed [PosW-1:0] wrap_to(input axis_t a,
                                                    input logic [RangeW-1:0] r,
                                                    input logic [RangeW-1:0] m);
    logic signed [RangeW+1:0] off;
    logic signed [PosW+1:0] sum;
    off = a.neg ? ((RangeW+2)'(r) - (RangeW+2)'(m)) : ((RangeW+2)'(m) - (RangeW+2)'(r));
    sum = (PosW+2)'(a.ctr) + ((PosW+2)'(off) <<< FracBits);
    return sat32(sum);
  endfunction

  logic [NumStages-1:0] v_q;
  job_t                 j_q  [NumStages];
  logic [RangeW-1:0]    rx_q [NumStages];
  logic [RangeW-1:0]    ry_q [NumStages];
  logic [RangeW-1:0]    rz_q [NumStages];
  logic                 vo_q;
  out_req_t             o_q;
  logic                 en;
  job_t                 jl;

  // the whole back part moves together whenever the output register can take
  assign en = !vo_q || out_ready_i;
  assign job_ready_o = en;
  assign jl = j_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[NumStages-2:0], job_valid_i};
      vo_q <= v_q[NumStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_q[0]  <= job_i;
      rx_q[0] <= rem_step('0, chunk(job_i.ax.whole, 0), job_i.hr);
      ry_q[0] <= rem_step('0, chunk(job_i.ay.whole, 0), job_i.vr);
      rz_q[0] <= rem_step('0, chunk(job_i.az.whole, 0), job_i.hr);
      for (int k = 1; k < NumStages; k++) begin
        j_q[k]  <= j_q[k-1];
        rx_q[k] <= rem_step(rx_q[k-1], chunk(j_q[k-1].ax.whole, k), j_q[k-1].hr);
        ry_q[k] <= rem_step(ry_q[k-1], chunk(j_q[k-1].ay.whole, k), j_q[k-1].vr);
        rz_q[k] <= rem_step(rz_q[k-1], chunk(j_q[k-1].az.whole, k), j_q[k-1].hr);
      end
      o_q.new_pos_x <= jl.ax.wrap ? wrap_to(jl.ax, jl.hr, rx_q[NumStages-1]) : jl.ax.pos;
      o_q.new_pos_y <= jl.ay.wrap ? wrap_to(jl.ay, jl.vr, ry_q[NumStages-1]) : jl.ay.pos;
      o_q.new_pos_z <= jl.az.wrap ? wrap_to(jl.az, jl.hr, rz_q[NumStages-1]) : jl.az.pos;
      o_q.new_vel_y <= jl.vel_y;
      o_q.new_delay <= jl.delay;
      o_q.new_mark  <= jl.mark;
      o_q.killed    <= jl.kill;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = o_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !out_ready_i) |=> vo_q) else $error("result dropped");

  a_kill_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && o_q.killed) |-> (o_q.new_mark == '0 && o_q.new_vel_y == '0))
    else $error("killed fields");

  a_wait_nokill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && j_q[0].waiting) |-> !j_q[0].kill) else $error("waiting killed");

endmodule

// ===== rtl/particle_advance_and_wrap.sv =====
// Particle advance and wrap: one particle record per request, one result per
// request, at one request per clock sustained. From an accepted input to a
// visible result a request passes a front register (move, offset, window
// test, kill decision), a four-entry queue that shows an entry in the cycle after
// it is written, eleven remainder stages that reduce each offset modulo its range
// three bits at a time, and a wrap stage that also serves as the output register.
// While the result is held off the back part stalls as a whole; the queue and the
// front register take five more requests before the input stalls. Range registers
// are written through the cfg port (index 0 horizontal, 1 vertical) and a zero
// range acts as 1.
module particle_advance_and_wrap import paw_pkg::*; #(
  parameter int FracBits = DefaultFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RangeW-1:0]  cfg_data_i,
  paw_if.sink                in_if,
  paw_if.source              out_if
);

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  paw_front #(.FracBits(FracBits)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  paw_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_job)
  );

  paw_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import paw_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RangeW-1:0] cfg_data_i = '0;

  paw_if #(.T(in_req_t)) in_if ();
  paw_if #(.T(out_req_t)) out_if ();

  particle_advance_and_wrap u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if(in_if.sink),
    .out_if(out_if.source)
  );

  always #10 clk_i = ~clk_i;

  // range registers as the block should hold them
  logic [RangeW-1:0] h_range;
  logic [RangeW-1:0] v_range;
  out_req_t exp_q[$];
  int n_err;
  int n_sent;
  int n_checked;
  int n_killed;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_rx;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  function automatic logic signed [PosW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[PosW-1:0];
  endfunction

  // side: 1 above window, -1 below, 0 inside; rem gets whole offset mod r
  function automatic int window_side(longint p, longint c, longint r, output longint rem);
    longint d;
    longint mag;
    longint whole;
    d = p - c;
    mag = (d < 0) ? -d : d;
    whole = mag >>> DefaultFracBits;
    rem = whole % r;
    if (whole > r) return (d < 0) ? -1 : 1;
    return 0;
  endfunction

  function automatic logic signed [PosW-1:0] wrap_pos(longint c, longint r, longint rem,
                                                       int side);
    longint off;
    off = (side > 0) ? (rem - r) : (r - rem);
    return clamp32(c + off * (64'sd1 <<< DefaultFracBits));
  endfunction

  function automatic out_req_t advance_particle(in_req_t p);
    out_req_t o;
    longint px, py, pz, hr, vr, rem;
    logic [DelayW-1:0] dly;
    bit waiting;
    int side;
    hr = (h_range == '0) ? 64'sd1 : longint'(h_range);
    vr = (v_range == '0) ? 64'sd1 : longint'(v_range);
    px = longint'(p.pos_x); py = longint'(p.pos_y); pz = longint'(p.pos_z);
    dly = p.delay;
    waiting = 0;
    o.new_vel_y = p.vel_y;
    o.new_mark = p.mark;
    o.killed = 1'b0;
    if (dly != '0) begin
      dly = dly - 16'd1;
      waiting = (dly != '0);
    end
    if (!waiting) begin
      px = longint'(clamp32(px + p.vel_x));
      py = longint'(clamp32(py + p.vel_y));
      pz = longint'(clamp32(pz + p.vel_z));
      side = window_side(px, longint'(p.center_x), hr, rem);
      if (side != 0) px = longint'(wrap_pos(longint'(p.center_x), hr, rem, side));
      side = window_side(py, longint'(p.center_y), vr, rem);
      if (side < 0 && p.effect_timer < TimerRunning) begin
        o.new_vel_y = '0;
        o.new_mark = '0;
        o.killed = 1'b1;
      end else if (side != 0) begin
        py = longint'(wrap_pos(longint'(p.center_y), vr, rem, side));
      end
      side = window_side(pz, longint'(p.center_z), hr, rem);
      if (side != 0) pz = longint'(wrap_pos(longint'(p.center_z), hr, rem, side));
    end
    o.new_pos_x = px[PosW-1:0];
    o.new_pos_y = py[PosW-1:0];
    o.new_pos_z = pz[PosW-1:0];
    o.new_delay = dly;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    n_err++;
  endtask

  task automatic send_particle(in_req_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= p;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    exp_q.push_back(advance_particle(p));
    n_sent++;
  endtask

  // drop valid after the last request of a burst
  task automatic idle_input();
    in_if.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_if.ready <= !hold_rx &&
                      !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_req_t got;
    out_req_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected result", longint'(got.new_pos_x), 0);
      end else begin
        want = exp_q.pop_front();
        n_checked++;
        if (got.killed) n_killed++;
        if (got.new_pos_x !== want.new_pos_x)
          report_mismatch("new_pos_x", got.new_pos_x, want.new_pos_x);
        if (got.new_pos_y !== want.new_pos_y)
          report_mismatch("new_pos_y", got.new_pos_y, want.new_pos_y);
        if (got.new_pos_z !== want.new_pos_z)
          report_mismatch("new_pos_z", got.new_pos_z, want.new_pos_z);
        if (got.new_vel_y !== want.new_vel_y)
          report_mismatch("new_vel_y", got.new_vel_y, want.new_vel_y);
        if (got.new_delay !== want.new_delay)
          report_mismatch("new_delay", got.new_delay, want.new_delay);
        if (got.new_mark !== want.new_mark)
          report_mismatch("new_mark", got.new_mark, want.new_mark);
        if (got.killed !== want.killed)
          report_mismatch("killed", got.killed, want.killed);
      end
    end
  end

  task automatic drain();
    idle_input();
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_range(cfg_idx_e idx, logic [RangeW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgHRange) h_range = val;
    else v_range = val;
    @(posedge clk_i);
  endtask

  function automatic logic signed [PosW-1:0] near(logic signed [PosW-1:0] c, int span);
    return clamp32(longint'(c) + $signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic in_req_t rand_particle(int mode);
    in_req_t p;
    int hs, vs;
    p.vel_x = 16'($urandom); p.vel_y = 16'($urandom); p.vel_z = 16'($urandom);
    p.mark = 8'($urandom);
    p.center_x = $urandom; p.center_y = $urandom; p.center_z = $urandom;
    case ($urandom_range(3))
      0: p.delay = '0;
      1: p.delay = 16'd1;
      2: p.delay = 16'($urandom_range(2, 5));
      default: p.delay = 16'($urandom);
    endcase
    p.effect_timer = ($urandom_range(1)) ? 7'd100 : 7'($urandom);
    hs = (int'(h_range) + 4) * 256 * 2;
    vs = (int'(v_range) + 4) * 256 * 2;
    if (mode == 0) begin
      // around the window edges, where wrap and kill happen
      p.pos_x = near(p.center_x, hs);
      p.pos_y = near(p.center_y, vs);
      p.pos_z = near(p.center_z, hs);
    end else begin
      p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
    end
    return p;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_particle(rand_particle($urandom_range(3) == 0));
  endtask

  task automatic test_directed();
    in_req_t p;
    p = '0;
    p.effect_timer = 7'd100;
    send_particle(p);
    // still waiting and last delay step
    p.delay = 16'hffff; p.mark = 8'hff; p.pos_x = 32'sh7fffffff;
    send_particle(p);
    p.delay = 16'd2; send_particle(p);
    p.delay = 16'd1; send_particle(p);
    // saturation both ways
    p = '0; p.delay = '0; p.effect_timer = 7'd100;
    p.pos_x = 32'sh7fffff00; p.vel_x = 16'sh7fff;
    p.pos_y = 32'sh80000010; p.vel_y = -16'sh8000;
    p.pos_z = 32'sh7fffffff; p.vel_z = 16'sh7fff;
    p.center_x = 32'sh80000000; p.center_y = 32'sh7fffffff;
    p.center_z = 32'sh80000000;
    send_particle(p);
    p.center_x = 32'sh7fffffff; p.center_z = 32'sh7fffffff;
    p.pos_x = 32'sh80000000; p.pos_z = 32'sh80000000; p.vel_x = -16'sh8000;
    p.vel_z = -16'sh8000;
    send_particle(p);
    // below window: killed when timer ending, wrapped when running or above
    p = '0; p.mark = 8'ha5; p.vel_y = 16'sh1234;
    p.pos_y = -32'sd1000 * 256;
    p.effect_timer = 7'd99; send_particle(p);
    p.effect_timer = 7'd0; send_particle(p);
    p.effect_timer = 7'd100; send_particle(p);
    p.effect_timer = 7'd127; send_particle(p);
    // just inside and just outside both sides
    p = '0; p.effect_timer = 7'd100;
    p.pos_x = 32'sd550 * 256 + 255; p.pos_z = -(32'sd551 * 256);
    p.pos_y = 32'sd167 * 256; send_particle(p);
    p.pos_x = -(32'sd550 * 256 + 255); p.pos_z = 32'sd5000 * 256 + 7;
    p.pos_y = -(32'sd166 * 256 + 255); p.effect_timer = 7'd50; send_particle(p);
    drain();
  endtask

  task automatic test_ranges();
    write_range(CfgHRange, 15'd0);
    write_range(CfgVRange, 15'd0);
    run_random(60);
    drain();
    write_range(CfgHRange, 15'h7fff);
    write_range(CfgVRange, 15'h7fff);
    run_random(60);
    drain();
    write_range(CfgHRange, 15'd1);
    write_range(CfgVRange, 15'd2);
    run_random(60);
    drain();
    write_range(CfgHRange, 15'($urandom_range(1, 32767)));
    write_range(CfgVRange, 15'($urandom_range(1, 32767)));
    run_random(60);
    drain();
    write_range(CfgHRange, HRangeReset);
    write_range(CfgVRange, VRangeReset);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      run_random(40);
    join
    drain();
  endtask

  task automatic test_random_stream();
    send_idle_pct = 23; recv_idle_pct = 77;
    run_random(550);
    send_idle_pct = 77; recv_idle_pct = 23;
    run_random(550);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_random(550);
    drain();
  endtask

  initial begin
    h_range = HRangeReset;
    v_range = VRangeReset;
    n_err = 0; n_sent = 0; n_checked = 0; n_killed = 0;
    send_idle_pct = 23; recv_idle_pct = 77; hold_rx = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_ranges();
    test_backpressure();
    test_random_stream();
    if (exp_q.size() != 0) begin
      $display("ERROR: %0d results never arrived", exp_q.size());
      n_err++;
    end
    $display("Covered %0d particles, %0d results checked, %0d kills, %0d mismatches",
             n_sent, n_checked, n_killed, n_err);
    $display("Range extremes 0, 1 and 32767 used; output held off for 300 cycles once");
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
